// File: rtl/lmf_pkg.sv
// ============================================================================
// lmf_pkg: shared definitions for the first local maximum finder
// Register indexes, field widths and the default sizes handed to the modules.
// ============================================================================
`default_nettype none

package lmf_pkg;

    // Default sizes for the top-level parameters.
    localparam int DEFAULT_MAX_ROWS     = 64;
    localparam int DEFAULT_MAX_COLUMNS  = 64;
    localparam int DEFAULT_SAMPLE_WIDTH = 16;

    // Configuration port layout.
    localparam int CFG_INDEX_WIDTH   = 4;
    localparam int COUNT_FIELD_WIDTH = 7;
    localparam logic [COUNT_FIELD_WIDTH-1:0] COUNT_RESET_VALUE = 7'd64;

    // Width of the reported row and column.
    localparam int POS_OUT_WIDTH = 6;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_ROW_COUNT    = 4'd0,
        CFG_COLUMN_COUNT = 4'd1
    } cfg_index_t;

endpackage

`default_nettype wire

// File: rtl/lmf_line_cell.sv
// ============================================================================
// lmf_line_cell: one storage cell of a line store
// Holds one sample; on a shift it takes either the new sample (when it is the
// entry point of the line) or the sample of its left neighbor.
// ============================================================================
`default_nettype none

module lmf_line_cell
    import lmf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
) (
    input  wire logic                    clk,
    input  wire logic                    shift_en,
    input  wire logic                    inject,
    input  wire logic [SAMPLE_WIDTH-1:0] din,
    input  wire logic [SAMPLE_WIDTH-1:0] prev,
    output logic      [SAMPLE_WIDTH-1:0] q
);

    logic [SAMPLE_WIDTH-1:0] q_reg;
    logic [SAMPLE_WIDTH-1:0] q_next;

    always_comb
    begin
        q_next = inject ? din : prev;
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// File: rtl/lmf_line_store.sv
// ============================================================================
// lmf_line_store: programmable-length delay line built from a chain of cells
// A sample enters at the cell that lies cols cells before the tail, so the
// tail shows the sample accepted exactly cols beats earlier.
// ============================================================================
`default_nettype none

module lmf_line_store
    import lmf_pkg::*;
#(
    parameter int MAX_COLUMNS  = DEFAULT_MAX_COLUMNS,
    parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH,
    localparam int CCW = $clog2(MAX_COLUMNS + 1)
) (
    input  wire logic                    clk,
    input  wire logic                    shift_en,
    input  wire logic [CCW-1:0]          cols,
    input  wire logic [SAMPLE_WIDTH-1:0] din,
    output logic      [SAMPLE_WIDTH-1:0] tail
);

    logic [SAMPLE_WIDTH-1:0] cell_q [MAX_COLUMNS];

    for (genvar k = 0; k < MAX_COLUMNS; k++)
    begin : g_cell
        localparam logic [CCW-1:0] ENTRY_LENGTH = CCW'(MAX_COLUMNS - k);
        logic                    inject;
        logic [SAMPLE_WIDTH-1:0] prev;

        assign inject = (cols == ENTRY_LENGTH);
        if (k == 0)
        begin : g_first
            assign prev = din;
        end
        else
        begin : g_rest
            assign prev = cell_q[k-1];
        end

        lmf_line_cell #(
            .SAMPLE_WIDTH(SAMPLE_WIDTH)
        ) u_cell (
            .clk     (clk),
            .shift_en(shift_en),
            .inject  (inject),
            .din     (din),
            .prev    (prev),
            .q       (cell_q[k])
        );
    end

    assign tail = cell_q[MAX_COLUMNS-1];

endmodule

`default_nettype wire

// File: rtl/lmf_window.sv
// ============================================================================
// lmf_window: 3x3 sample window with strict-maximum test
// Shifts one column left per beat and checks whether the center is strictly
// greater than all eight neighbors.
// ============================================================================
`default_nettype none

module lmf_window
    import lmf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
) (
    input  wire logic                           clk,
    input  wire logic                           shift_en,
    input  wire logic signed [SAMPLE_WIDTH-1:0] top_in,
    input  wire logic signed [SAMPLE_WIDTH-1:0] mid_in,
    input  wire logic signed [SAMPLE_WIDTH-1:0] bot_in,
    output logic                                center_is_max
);

    logic signed [SAMPLE_WIDTH-1:0] win_reg  [3][3];
    logic signed [SAMPLE_WIDTH-1:0] win_next [3][3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = top_in;
        win_next[1][2] = mid_in;
        win_next[2][2] = bot_in;
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            win_reg <= win_next;
        end
    end

    // Eight independent compares against the center.
    always_comb
    begin
        center_is_max = 1'b1;
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if ((r != 1 || k != 1) && (win_reg[r][k] >= win_reg[1][1]))
                begin
                    center_is_max = 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/first_local_maximum_finder.sv
// ============================================================================
// first_local_maximum_finder: first strict 3x3 local maximum of a raster frame
// Result: a frame's last sample passes through stage one into the result register.
// Throughput: one sample per cycle; input stalls only while a finished frame
// waits behind an unaccepted result beat. Reset clears position and found
// state and sets both counts to 64; line stores and window hold no reset.
// ============================================================================
`default_nettype none

module first_local_maximum_finder
    import lmf_pkg::*;
#(
    parameter int MAX_ROWS     = DEFAULT_MAX_ROWS,
    parameter int MAX_COLUMNS  = DEFAULT_MAX_COLUMNS,
    parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    // Configuration write channel.
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  wire logic [COUNT_FIELD_WIDTH-1:0]   cfg_data,

    // Sample stream in raster order.
    input  wire logic                           sample_valid,
    output logic                                sample_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_value,

    // One result beat per frame.
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output logic                                found,
    output logic [POS_OUT_WIDTH-1:0]            max_row,
    output logic [POS_OUT_WIDTH-1:0]            max_column
);

    // Counts need room for the maximum itself; positions only for max - 1.
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLUMNS + 1);
    localparam int PRW = $clog2(MAX_ROWS);
    localparam int PCW = $clog2(MAX_COLUMNS);

    // ------------------------------------------------------------------
    // Configuration registers. Port always ready; a write to a known register
    // restarts the frame. Write only while the block is idle; it is not checked.
    // ------------------------------------------------------------------
    logic [COUNT_FIELD_WIDTH-1:0] row_cfg_reg;
    logic [COUNT_FIELD_WIDTH-1:0] col_cfg_reg;
    logic                         cfg_write;
    logic                         cfg_restart;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        case (cfg_index)
            CFG_ROW_COUNT:    cfg_restart = cfg_write;
            CFG_COLUMN_COUNT: cfg_restart = cfg_write;
            default:          cfg_restart = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cfg_reg <= COUNT_RESET_VALUE;
            col_cfg_reg <= COUNT_RESET_VALUE;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_ROW_COUNT)
            begin
                row_cfg_reg <= cfg_data;
            end
            if (cfg_index == CFG_COLUMN_COUNT)
            begin
                col_cfg_reg <= cfg_data;
            end
        end
    end

    // A count of zero acts as one, and a count above the maximum as the maximum.
    logic [RCW-1:0] rows_eff;
    logic [CCW-1:0] cols_eff;

    always_comb
    begin
        if (row_cfg_reg == '0)
        begin
            rows_eff = RCW'(1);
        end
        else if (32'(row_cfg_reg) > MAX_ROWS)
        begin
            rows_eff = RCW'(MAX_ROWS);
        end
        else
        begin
            rows_eff = RCW'(row_cfg_reg);
        end

        if (col_cfg_reg == '0)
        begin
            cols_eff = CCW'(1);
        end
        else if (32'(col_cfg_reg) > MAX_COLUMNS)
        begin
            cols_eff = CCW'(MAX_COLUMNS);
        end
        else
        begin
            cols_eff = CCW'(col_cfg_reg);
        end
    end

    // ------------------------------------------------------------------
    // Handshake. Stage one holds the position of the sample whose window is
    // in the window registers. It only stalls when it carries the last
    // sample of a frame and the result register is still occupied.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic s1_last_reg;
    logic s1_cand_reg;
    logic [PRW-1:0] s1_row_reg;
    logic [PCW-1:0] s1_col_reg;
    logic s1_adv;
    logic s1_fire;
    logic accept;
    logic result_valid_reg, result_valid_next;

    assign s1_adv       = !s1_valid_reg || !s1_last_reg || !result_valid_reg || result_ready;
    assign s1_fire      = s1_valid_reg && s1_adv;
    assign sample_ready = s1_adv;
    assign accept       = sample_valid && sample_ready;

    // ------------------------------------------------------------------
    // Raster position of the next sample.
    // ------------------------------------------------------------------
    logic [PRW-1:0] cur_row_reg, cur_row_next;
    logic [PCW-1:0] cur_col_reg, cur_col_next;
    logic [CCW:0]   col_inc;
    logic [RCW:0]   row_inc;
    logic           col_last;
    logic           row_last;
    logic           cand;

    assign col_inc  = {1'b0, CCW'(cur_col_reg)} + (CCW+1)'(1);
    assign row_inc  = {1'b0, RCW'(cur_row_reg)} + (RCW+1)'(1);
    assign col_last = (col_inc >= {1'b0, cols_eff});
    assign row_last = (row_inc >= {1'b0, rows_eff});
    assign cand     = (cur_row_reg >= PRW'(2)) && (cur_col_reg >= PCW'(2));

    always_comb
    begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        if (cfg_restart)
        begin
            cur_row_next = '0;
            cur_col_next = '0;
        end
        else if (accept)
        begin
            if (!col_last)
            begin
                cur_col_next = cur_col_reg + PCW'(1);
            end
            else
            begin
                cur_col_next = '0;
                cur_row_next = row_last ? '0 : cur_row_reg + PRW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg <= '0;
            cur_col_reg <= '0;
        end
        else
        begin
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
        end
    end

    // ------------------------------------------------------------------
    // Line stores and window. The first line store gives the sample one row
    // up; the second, fed from the first, gives the sample two rows up.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_WIDTH-1:0] above;
    logic signed [SAMPLE_WIDTH-1:0] above2;
    logic                           center_is_max;

    lmf_line_store #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_line_prev (
        .clk     (clk),
        .shift_en(accept),
        .cols    (cols_eff),
        .din     (sample_value),
        .tail    (above)
    );

    lmf_line_store #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_line_prev2 (
        .clk     (clk),
        .shift_en(accept),
        .cols    (cols_eff),
        .din     (above),
        .tail    (above2)
    );

    lmf_window #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_window (
        .clk          (clk),
        .shift_en     (accept),
        .top_in       (above2),
        .mid_in       (above),
        .bot_in       (sample_value),
        .center_is_max(center_is_max)
    );

    // ------------------------------------------------------------------
    // Stage one registers.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg <= col_last && row_last;
            s1_cand_reg <= cand;
            s1_row_reg  <= cur_row_reg;
            s1_col_reg  <= cur_col_reg;
        end
    end

    // ------------------------------------------------------------------
    // Found tracking and the result register. Only the first hit of a frame
    // is kept; the last sample's own window still counts.
    // ------------------------------------------------------------------
    logic           found_reg;
    logic [PRW-1:0] found_row_reg;
    logic [PCW-1:0] found_col_reg;
    logic           hit;
    logic           final_found;
    logic [PRW-1:0] final_row;
    logic [PCW-1:0] final_col;
    logic                     found_out_reg;
    logic [POS_OUT_WIDTH-1:0] max_row_reg;
    logic [POS_OUT_WIDTH-1:0] max_col_reg;

    assign hit = s1_cand_reg && !found_reg && center_is_max;

    always_comb
    begin
        final_found = found_reg || hit;
        if (found_reg)
        begin
            final_row = found_row_reg;
            final_col = found_col_reg;
        end
        else if (hit)
        begin
            final_row = s1_row_reg - PRW'(1);
            final_col = s1_col_reg - PCW'(1);
        end
        else
        begin
            final_row = '0;
            final_col = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            found_row_reg <= '0;
            found_col_reg <= '0;
        end
        else if (cfg_restart || (s1_fire && s1_last_reg))
        begin
            found_reg     <= 1'b0;
            found_row_reg <= '0;
            found_col_reg <= '0;
        end
        else if (s1_fire && hit)
        begin
            found_reg     <= 1'b1;
            found_row_reg <= s1_row_reg - PRW'(1);
            found_col_reg <= s1_col_reg - PCW'(1);
        end
    end

    always_comb
    begin
        if (s1_fire && s1_last_reg)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    // Reported positions are cut or padded to the output width.
    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            found_out_reg <= final_found;
            max_row_reg   <= POS_OUT_WIDTH'(final_row);
            max_col_reg   <= POS_OUT_WIDTH'(final_col);
        end
    end

    assign result_valid = result_valid_reg;
    assign found        = found_out_reg;
    assign max_row      = max_row_reg;
    assign max_column   = max_col_reg;

endmodule

`default_nettype wire

// File: sim/first_local_maximum_finder_tb.sv
// ============================================================================
// first_local_maximum_finder_tb: self-checking bench for the 3x3 peak finder
// A short scripted sequence covers reset, degenerate frame sizes, extreme
// samples, equal neighbors and register writes that cut a frame short. Random
// frames of many sizes and value styles follow. Every result beat is checked
// against a typed result or the in-bench raster predictor; both channels idle at random.
// ============================================================================
`default_nettype none

module first_local_maximum_finder_tb;
    import lmf_pkg::*;

    localparam int MAX_ROWS     = DEFAULT_MAX_ROWS;
    localparam int MAX_COLUMNS  = DEFAULT_MAX_COLUMNS;
    localparam int SW           = DEFAULT_SAMPLE_WIDTH;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;

    // The result beat comes from stage one through the result register after the
    // last sample of a frame, so a few spare cycles are enough to be sure the
    // block has gone quiet.
    localparam int DRAIN_CYCLES = 4;
    localparam int DRAIN_LIMIT  = 20000;

    // Allow a wide margin over the slowest legal run.
    localparam int TIMEOUT_CYCLES = 1200000;

    // Target number of random samples, not counting the scripted part.
    localparam int SAMPLE_TARGET = 1250;
    localparam int MAX_REPORTED  = 10;

    typedef logic signed [SW-1:0] sample_t;

    localparam sample_t SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam sample_t SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam sample_t SAMPLE_NONE = '0;

    // Any index above the column count register is not mapped to anything.
    localparam int FIRST_UNMAPPED = int'(CFG_COLUMN_COUNT) + 1;
    localparam int LAST_UNMAPPED  = (1 << CFG_INDEX_WIDTH) - 1;
    localparam logic [CFG_INDEX_WIDTH-1:0] UNMAPPED_INDEX = CFG_INDEX_WIDTH'(LAST_UNMAPPED);
    localparam logic [CFG_INDEX_WIDTH-1:0] NO_INDEX = '0;

    typedef struct packed {
        logic                     found;
        logic [POS_OUT_WIDTH-1:0] row;
        logic [POS_OUT_WIDTH-1:0] column;
    } peak_report_t;

    localparam peak_report_t NO_PEAK     = '0;
    localparam peak_report_t CENTER_PEAK = '{1'b1, 6'd1, 6'd1};

    typedef enum logic {STEP_SAMPLE, STEP_REGISTER} step_kind_t;

    typedef enum int {FILL_WIDE, FILL_NARROW, FILL_EXTREME, FILL_PEAK} fill_style_t;

    typedef struct packed {
        step_kind_t                   kind;
        logic [CFG_INDEX_WIDTH-1:0]   index;
        logic [COUNT_FIELD_WIDTH-1:0] data;
        sample_t                      value;
        logic                         typed;
        peak_report_t                 report;
    } script_step_t;

    localparam int SCRIPT_LEN = 28;

    // Scripted opening. Rows marked typed carry a result that is obvious from
    // the frame itself; all other rows rely on the predictor.
    script_step_t script [SCRIPT_LEN] = '{
        // Right after reset the frame is 64 x 64: start one and cut it short.
        '{STEP_SAMPLE,   NO_INDEX,         7'd0,   16'sd100,    1'b0, NO_PEAK},
        '{STEP_SAMPLE,   NO_INDEX,         7'd0,   SAMPLE_MIN,  1'b0, NO_PEAK},
        '{STEP_SAMPLE,   NO_INDEX,         7'd0,   SAMPLE_MAX,  1'b0, NO_PEAK},
        // A zero count behaves as one row, so this is a 1 x 1 frame.
        '{STEP_REGISTER, CFG_ROW_COUNT,    7'd0,   SAMPLE_NONE, 1'b0, NO_PEAK},
        '{STEP_REGISTER, CFG_COLUMN_COUNT, 7'd1,   SAMPLE_NONE, 1'b0, NO_PEAK},
        '{STEP_SAMPLE,   NO_INDEX,         7'd0,   SAMPLE_MAX,  1'b1, NO_PEAK},
        '{STEP_SAMPLE,   NO_INDEX,         7'd0,   SAMPLE_MIN,  1'b1, NO_PEAK},
        // Smallest frame with an interior: a lone peak at the center.
        '{STEP_REGISTER, CFG_ROW_COUNT,    7'd3,   SAMPLE_NONE, 1'b0, NO_PEAK},
        '{STEP_REGISTER, CFG_COLUMN_COUNT, 7'd3,   SAMPLE_NONE, 1'b0, NO_PEAK},
        '{STEP_SAMPLE,   NO_INDEX,         7'd0,   SAMPLE_MIN,  1'b0, NO_PEAK},
        '{STEP_SAMPLE,   NO_INDEX,         7'd0,   SAMPLE_MIN,  1'b0, NO_PEAK},
        '{STEP_SAMPLE,   NO_INDEX,         7'd0,   SAMPLE_MIN,  1'b0, NO_PEAK},
        '{STEP_SAMPLE,   NO_INDEX,         7'd0,   SAMPLE_MIN,  1'b0, NO_PEAK},
        '{STEP_SAMPLE,   NO_INDEX,         7'd0,   SAMPLE_MAX,  1'b0, NO_PEAK},
        '{STEP_SAMPLE,   NO_INDEX,         7'd0,   SAMPLE_MIN,  1'b0, NO_PEAK},
        '{STEP_SAMPLE,   NO_INDEX,         7'd0,   SAMPLE_MIN,  1'b0, NO_PEAK},
        '{STEP_SAMPLE,   NO_INDEX,         7'd0,   SAMPLE_MIN,  1'b0, NO_PEAK},
        '{STEP_SAMPLE,   NO_INDEX,         7'd0,   SAMPLE_MIN,  1'b1, CENTER_PEAK},
        // An equal neighbor spoils the center. A write to an unmapped index
        // in the middle of the frame must leave the frame running.
        '{STEP_SAMPLE,   NO_INDEX,         7'd0,   16'sd0,      1'b0, NO_PEAK},
        '{STEP_SAMPLE,   NO_INDEX,         7'd0,   16'sd0,      1'b0, NO_PEAK},
        '{STEP_SAMPLE,   NO_INDEX,         7'd0,   16'sd0,      1'b0, NO_PEAK},
        '{STEP_SAMPLE,   NO_INDEX,         7'd0,   16'sd0,      1'b0, NO_PEAK},
        '{STEP_REGISTER, UNMAPPED_INDEX,   7'd2,   SAMPLE_NONE, 1'b0, NO_PEAK},
        '{STEP_SAMPLE,   NO_INDEX,         7'd0,   16'sd8,      1'b0, NO_PEAK},
        '{STEP_SAMPLE,   NO_INDEX,         7'd0,   16'sd8,      1'b0, NO_PEAK},
        '{STEP_SAMPLE,   NO_INDEX,         7'd0,   16'sd0,      1'b0, NO_PEAK},
        '{STEP_SAMPLE,   NO_INDEX,         7'd0,   16'sd0,      1'b0, NO_PEAK},
        '{STEP_SAMPLE,   NO_INDEX,         7'd0,   16'sd0,      1'b1, NO_PEAK}
    };

    // The first random phases go through the count extremes: above the maximum,
    // at the maximum, zero on both sides, one and two, mostly with a modest other side.
    localparam int FORCED_PHASES = 5;
    localparam logic [COUNT_FIELD_WIDTH-1:0] FORCED_ROWS [FORCED_PHASES] =
        '{7'd127, 7'd3, 7'd0, 7'd65, 7'd2};
    localparam logic [COUNT_FIELD_WIDTH-1:0] FORCED_COLUMNS [FORCED_PHASES] =
        '{7'd3, 7'd127, 7'd0, 7'd1, 7'd64};

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0]   cfg_index = '0;
    logic [COUNT_FIELD_WIDTH-1:0] cfg_data = '0;

    logic    sample_valid = 1'b0;
    logic    sample_ready;
    sample_t sample_value = '0;

    logic                     result_valid;
    logic                     result_ready = 1'b0;
    logic                     found;
    logic [POS_OUT_WIDTH-1:0] max_row;
    logic [POS_OUT_WIDTH-1:0] max_column;

    first_local_maximum_finder #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_COLUMNS  (MAX_COLUMNS),
        .SAMPLE_WIDTH (SW)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_value (sample_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .found        (found),
        .max_row      (max_row),
        .max_column   (max_column)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Raster predictor: its own copy of the line stores, window, position and
    // first-peak record. The stores start at zero; no decision ever looks at
    // an entry that the current frame has not written.
    // ------------------------------------------------------------------------
    logic [COUNT_FIELD_WIDTH-1:0] rows_setting = COUNT_RESET_VALUE;
    logic [COUNT_FIELD_WIDTH-1:0] columns_setting = COUNT_RESET_VALUE;

    sample_t     row_above     [MAX_COLUMNS] = '{default: '0};
    sample_t     row_two_above [MAX_COLUMNS] = '{default: '0};
    sample_t     neighborhood  [3][3]        = '{default: '{default: '0}};
    int unsigned pos_row = 0;
    int unsigned pos_column = 0;
    logic        peak_seen = 1'b0;
    int unsigned peak_row = 0;
    int unsigned peak_column = 0;

    peak_report_t expected_reports [$];

    // Shared bookkeeping for the summary and the verdict.
    int unsigned failures = 0;
    int unsigned samples_taken = 0;
    int unsigned frames_sent = 0;
    int unsigned frames_cut = 0;
    int unsigned register_writes = 0;
    int unsigned reports_checked = 0;
    int unsigned peaks_reported = 0;

    // When set, neither side inserts gaps, so the block runs at full rate.
    logic quiet_phase = 1'b0;

    function automatic int unsigned effective_count(
        input logic [COUNT_FIELD_WIDTH-1:0] setting,
        input int unsigned limit
    );
        if (setting == 0)
            return 1;
        if (setting > limit)
            return limit;
        return int'(setting);
    endfunction

    function automatic void restart_frame();
        pos_row = 0;
        pos_column = 0;
        peak_seen = 1'b0;
        peak_row = 0;
        peak_column = 0;
    endfunction

    function automatic void apply_register(
        input logic [CFG_INDEX_WIDTH-1:0]   index,
        input logic [COUNT_FIELD_WIDTH-1:0] data
    );
        if (index == CFG_ROW_COUNT)
            rows_setting = data;
        else if (index == CFG_COLUMN_COUNT)
            columns_setting = data;
        else
            return;
        // Any write to a real register throws away the frame in progress.
        restart_frame();
    endfunction

    // The center wins only if every one of its eight neighbors is lower.
    function automatic logic center_is_strict_peak();
        int i;
        int j;
        for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
                if ((i != 1 || j != 1) && neighborhood[i][j] >= neighborhood[1][1])
                    return 1'b0;
        return 1'b1;
    endfunction

    task automatic advance_raster(
        input  sample_t      value,
        output logic         emit,
        output peak_report_t report
    );
        int unsigned n_rows;
        int unsigned n_columns;
        int unsigned r;
        int unsigned c;
        int          k;
        sample_t     up_one;
        sample_t     up_two;
        n_rows = effective_count(rows_setting, MAX_ROWS);
        n_columns = effective_count(columns_setting, MAX_COLUMNS);
        r = (pos_row >= n_rows) ? n_rows - 1 : pos_row;
        c = (pos_column >= n_columns) ? n_columns - 1 : pos_column;
        up_one = row_above[c];
        up_two = row_two_above[c];
        for (k = 0; k < 3; k++)
        begin
            neighborhood[k][0] = neighborhood[k][1];
            neighborhood[k][1] = neighborhood[k][2];
        end
        neighborhood[0][2] = up_two;
        neighborhood[1][2] = up_one;
        neighborhood[2][2] = value;
        row_two_above[c] = up_one;
        row_above[c] = value;
        // The newest sample is the lower right corner, so the center under
        // test sits one row up and one column left of it.
        if (r >= 2 && c >= 2 && !peak_seen && center_is_strict_peak())
        begin
            peak_seen = 1'b1;
            peak_row = r - 1;
            peak_column = c - 1;
        end
        emit = 1'b0;
        report = NO_PEAK;
        if (c + 1 < n_columns)
        begin
            pos_column = c + 1;
            pos_row = r;
        end
        else if (r + 1 < n_rows)
        begin
            pos_column = 0;
            pos_row = r + 1;
        end
        else
        begin
            emit = 1'b1;
            if (peak_seen)
                report = '{1'b1, peak_row[POS_OUT_WIDTH-1:0],
                           peak_column[POS_OUT_WIDTH-1:0]};
            restart_frame();
        end
    endtask

    // ------------------------------------------------------------------------
    // Idle lengths: mostly none or short, now and then a long one.
    // ------------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (quiet_phase)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void note_failure(input string text);
        failures++;
        if (failures <= MAX_REPORTED)
            $display("ERROR at %0t: %s", $realtime, text);
    endfunction

    // ------------------------------------------------------------------------
    // Sample channel. Valid rises after the chosen gap and then holds, with
    // the value fixed, until the beat is taken. A zero gap keeps valid high
    // straight into the next beat.
    // ------------------------------------------------------------------------
    task automatic send_sample(
        input sample_t      value,
        input logic         use_typed,
        input peak_report_t typed_report
    );
        int unsigned  gap;
        logic         emit;
        peak_report_t report;
        gap = pick_gap();
        if (gap != 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_value <= value;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        samples_taken++;
        advance_raster(value, emit, report);
        if (emit)
        begin
            frames_sent++;
            expected_reports.push_back(use_typed ? typed_report : report);
        end
    endtask

    // Stop sending, let every outstanding result come back, then give the
    // block a few more cycles in case it is still chewing on a sample.
    task automatic settle();
        sample_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_register(
        input logic [CFG_INDEX_WIDTH-1:0]   index,
        input logic [COUNT_FIELD_WIDTH-1:0] data
    );
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        apply_register(index, data);
        register_writes++;
    endtask

    function automatic logic [COUNT_FIELD_WIDTH-1:0] pick_count();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return COUNT_FIELD_WIDTH'($urandom_range(1, 6));
        if (roll < 90)
            return COUNT_FIELD_WIDTH'($urandom_range(7, 12));
        if (roll < 95)
            return COUNT_FIELD_WIDTH'($urandom_range(13, 24));
        if (roll < 97)
            return '0;
        return COUNT_FIELD_WIDTH'($urandom_range(64, 127));
    endfunction

    function automatic logic [CFG_INDEX_WIDTH-1:0] pick_unmapped_index();
        return CFG_INDEX_WIDTH'($urandom_range(FIRST_UNMAPPED, LAST_UNMAPPED));
    endfunction

    // ------------------------------------------------------------------------
    // Result side: ready drops for random stretches, sometimes long ones.
    // ------------------------------------------------------------------------
    initial
    begin : result_backpressure
        int unsigned stall;
        @(posedge rst_n);
        forever
        begin
            stall = pick_gap();
            if (stall != 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Every accepted result beat is matched against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        peak_report_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_reports.size() == 0)
                note_failure($sformatf("result beat with nothing expected: found=%0d row=%0d col=%0d",
                                       found, max_row, max_column));
            else
            begin
                want = expected_reports.pop_front();
                reports_checked++;
                if (want.found)
                    peaks_reported++;
                if (found !== want.found || max_row !== want.row ||
                    max_column !== want.column)
                    note_failure($sformatf(
                        "result %0d: expected found=%0d row=%0d col=%0d, got found=%0d row=%0d col=%0d",
                        reports_checked, want.found, want.row, want.column,
                        found, max_row, max_column));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int           step;
        int           phase;
        int           frame;
        int           i;
        int           n;
        int           send_len;
        int           probe_at;
        int           frames_in_phase;
        int           peak_at;
        int           waited;
        int           offset;
        int unsigned  n_rows;
        int unsigned  n_columns;
        logic [COUNT_FIELD_WIDTH-1:0] new_rows;
        logic [COUNT_FIELD_WIDTH-1:0] new_columns;
        fill_style_t  style;
        sample_t      frame_samples [$];

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Scripted opening.
        for (step = 0; step < SCRIPT_LEN; step++)
        begin
            if (script[step].kind == STEP_REGISTER)
                write_register(script[step].index, script[step].data);
            else
                send_sample(script[step].value, script[step].typed, script[step].report);
        end

        // Random phases: each picks new counts, then streams a few frames.
        phase = 0;
        offset = samples_taken;
        while (samples_taken - offset < SAMPLE_TARGET)
        begin
            if (phase < FORCED_PHASES)
            begin
                new_rows = FORCED_ROWS[phase];
                new_columns = FORCED_COLUMNS[phase];
                frames_in_phase = 1;
            end
            else
            begin
                new_rows = pick_count();
                new_columns = pick_count();
                // Keep the big frames rare so most of the run is short frames.
                if (effective_count(new_rows, MAX_ROWS) *
                    effective_count(new_columns, MAX_COLUMNS) > 256)
                    new_columns = COUNT_FIELD_WIDTH'($urandom_range(1, 4));
                frames_in_phase = $urandom_range(1, 4);
            end
            quiet_phase = ($urandom_range(0, 3) == 0);

            if ($urandom_range(0, 1) == 0)
            begin
                write_register(CFG_ROW_COUNT, new_rows);
                write_register(CFG_COLUMN_COUNT, new_columns);
            end
            else
            begin
                write_register(CFG_COLUMN_COUNT, new_columns);
                write_register(CFG_ROW_COUNT, new_rows);
            end
            if ($urandom_range(0, 6) == 0)
                write_register(pick_unmapped_index(),
                               COUNT_FIELD_WIDTH'($urandom_range(0, 127)));

            n_rows = effective_count(rows_setting, MAX_ROWS);
            n_columns = effective_count(columns_setting, MAX_COLUMNS);
            n = n_rows * n_columns;

            for (frame = 0; frame < frames_in_phase; frame++)
            begin
                style = fill_style_t'($urandom_range(0, 3));
                frame_samples.delete();
                for (i = 0; i < n; i++)
                begin
                    case (style)
                        FILL_WIDE:
                            frame_samples.push_back(sample_t'($urandom_range(0, 65535)));
                        FILL_NARROW:
                            frame_samples.push_back(sample_t'(int'($urandom_range(0, 2)) - 1));
                        FILL_EXTREME:
                            case ($urandom_range(0, 3))
                                0: frame_samples.push_back(SAMPLE_MIN);
                                1: frame_samples.push_back(SAMPLE_MAX);
                                2: frame_samples.push_back(-16'sd1);
                                default: frame_samples.push_back(16'sd0);
                            endcase
                        default:
                            frame_samples.push_back(sample_t'(int'($urandom_range(0, 8)) - 4));
                    endcase
                end
                // Plant a clear peak somewhere in the interior.
                if (style == FILL_PEAK && n_rows >= 3 && n_columns >= 3)
                begin
                    peak_at = $urandom_range(1, n_rows - 2) * n_columns +
                              $urandom_range(1, n_columns - 2);
                    frame_samples[peak_at] = 16'sd100;
                end

                // Now and then the frame is broken off part way; the next
                // register write must discard it without a result.
                send_len = n;
                if (n > 1 && $urandom_range(0, 9) == 0)
                    send_len = $urandom_range(1, n - 1);
                // Now and then an unmapped write lands mid-frame and must
                // change nothing.
                probe_at = -1;
                if (n > 1 && $urandom_range(0, 19) == 0)
                    probe_at = $urandom_range(1, n - 1);

                for (i = 0; i < send_len; i++)
                begin
                    if (i == probe_at)
                        write_register(pick_unmapped_index(),
                                       COUNT_FIELD_WIDTH'($urandom_range(0, 127)));
                    send_sample(frame_samples[i], 1'b0, NO_PEAK);
                end
                if (send_len < n)
                begin
                    frames_cut++;
                    break;
                end
                // Occasionally hold off until all results are home.
                if ($urandom_range(0, 9) == 0)
                    settle();
            end
            phase++;
        end

        // Wind down: wait for the last results, then a little longer to catch
        // any stray beat.
        sample_valid <= 1'b0;
        waited = 0;
        while (expected_reports.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (2 * DRAIN_CYCLES) @(posedge clk);
        if (expected_reports.size() != 0)
            note_failure($sformatf("%0d expected results never arrived",
                                   expected_reports.size()));

        $display("Run covered %0d samples in %0d complete frames, %0d frames cut short, %0d register writes.",
                 samples_taken, frames_sent, frames_cut, register_writes);
        $display("Checked %0d result beats (%0d with a peak found); %0d failures.",
                 reports_checked, peaks_reported, failures);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Timeout after %0d cycles.", TIMEOUT_CYCLES);
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
